>>> src/sha256_message_hasher_macros.svh
// assertion macros for the sha256 message hasher
// used by the core modules; no dependencies
`ifndef SHA256_MESSAGE_HASHER_MACROS_SVH
`define SHA256_MESSAGE_HASHER_MACROS_SVH

// implication that must hold at every clock edge outside reset
`define SHA_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sha256 check failed");

// next-cycle implication
`define SHA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sha256 check failed");

`endif

>>> src/sha_pkg.sv
// sha256 package: constants, round constant table, rotate-right function
// no dependencies
package sha_pkg;

  localparam int WordBits = 32;
  localparam int BlockWords = 16;
  localparam int Rounds = 64;
  localparam logic [7:0] PadByte = 8'h80;
  localparam logic [5:0] LenPos = 6'd56;

  typedef logic [31:0] word_t;
  typedef word_t [7:0] chain_t;

  localparam chain_t InitHash = {
    32'h5BE0CD19, 32'h1F83D9AB, 32'h9B05688C, 32'h510E527F,
    32'hA54FF53A, 32'h3C6EF372, 32'hBB67AE85, 32'h6A09E667
  };

  localparam word_t [63:0] RoundK = {
    32'hC67178F2, 32'hBEF9A3F7, 32'hA4506CEB, 32'h90BEFFFA,
    32'h8CC70208, 32'h84C87814, 32'h78A5636F, 32'h748F82EE,
    32'h682E6FF3, 32'h5B9CCA4F, 32'h4ED8AA4A, 32'h391C0CB3,
    32'h34B0BCB5, 32'h2748774C, 32'h1E376C08, 32'h19A4C116,
    32'h106AA070, 32'hF40E3585, 32'hD6990624, 32'hD192E819,
    32'hC76C51A3, 32'hC24B8B70, 32'hA81A664B, 32'hA2BFE8A1,
    32'h92722C85, 32'h81C2C92E, 32'h766A0ABB, 32'h650A7354,
    32'h53380D13, 32'h4D2C6DFC, 32'h2E1B2138, 32'h27B70A85,
    32'h14292967, 32'h06CA6351, 32'hD5A79147, 32'hC6E00BF3,
    32'hBF597FC7, 32'hB00327C8, 32'hA831C66D, 32'h983E5152,
    32'h76F988DA, 32'h5CB0A9DC, 32'h4A7484AA, 32'h2DE92C6F,
    32'h240CA1CC, 32'h0FC19DC6, 32'hEFBE4786, 32'hE49B69C1,
    32'hC19BF174, 32'h9BDC06A7, 32'h80DEB1FE, 32'h72BE5D74,
    32'h550C7DC3, 32'h243185BE, 32'h12835B01, 32'hD807AA98,
    32'hAB1C5ED5, 32'h923F82A4, 32'h59F111F1, 32'h3956C25B,
    32'hE9B5DBA5, 32'hB5C0FBCF, 32'h71374491, 32'h428A2F98
  };

  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } comp_ctl_t;

  function automatic word_t rotr(input word_t x, input int n);
    rotr = (x >> n) | (x << (WordBits - n));
  endfunction

endpackage

>>> src/sha_round.sv
// sha256 compression unit: one round per cycle over a 16-word schedule window
// depends on sha_pkg
module sha_round
  import sha_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  word_t [15:0]          block_in,
  input  chain_t                chain_in,
  output comp_ctl_t             ctl,
  output chain_t                chain_out
);

  logic [5:0]   round;
  logic         busy;
  logic         done;
  word_t [15:0] sched;
  word_t [7:0]  v;
  word_t        w_new;
  word_t        s0;
  word_t        s1;
  word_t        t1;
  word_t        t2;
  word_t        big0;
  word_t        big1;
  word_t        ch;
  word_t        maj;

  always_comb begin
    s0 = rotr(sched[1], 7) ^ rotr(sched[1], 18) ^ (sched[1] >> 3);
    s1 = rotr(sched[14], 17) ^ rotr(sched[14], 19) ^ (sched[14] >> 10);
    w_new = s1 + sched[9] + s0 + sched[0];
    big1 = rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25);
    ch = v[6] ^ (v[4] & (v[5] ^ v[6]));
    t1 = v[7] + big1 + ch + RoundK[round] + sched[0];
    big0 = rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22);
    maj = (v[0] & v[1]) | (v[2] & (v[0] | v[1]));
    t2 = big0 + maj;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      round <= '0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        busy <= 1'b1;
        round <= '0;
      end else if (busy) begin
        round <= round + 6'd1;
        if (round == 6'(Rounds - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      sched <= block_in;
      v <= chain_in;
    end else if (busy) begin
      sched <= {w_new, sched[15:1]};
      v <= {v[6:4], v[3] + t1, v[2:0], t1 + t2};
    end
  end

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      chain_out[i] = chain_in[i] + v[i];
    end
  end

  assign ctl = '{start: start, busy: busy, done: done};

  `include "sha256_message_hasher_macros.svh"

  `SHA_ASSERT_NEXT(a_done_pulse, done, !done)
  `SHA_ASSERT_IMP(a_done_after_last, done, !busy && round == '0)
  `SHA_ASSERT_NEXT(a_start_runs, start && !busy, busy && round == '0)

endmodule

>>> src/sha256_message_hasher.sv
// sha256 message hasher top level: byte packer, padding sequencer, digest output
// depends on sha_pkg and sha_round
// An accepted word is unpacked one byte per cycle, save while a block is being
// compressed. The input is held off from the accepting cycle until the word's
// bytes are all unpacked. Each time 64 bytes have gathered, the compression
// unit runs 64 rounds, one per cycle, and the input is held off until it is done.
// A last word adds the padding bytes, one per cycle save during compression, with
// one or two further compressions. Then eight digest words are offered one per
// cycle while out_ready is high; no new word is taken until all eight have gone.
module sha256_message_hasher
  import sha_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] data_word,
  input  logic [2:0]  valid_bytes,
  input  logic        last_word,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] digest_word,
  output logic [2:0]  word_index,
  output logic        digest_end
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_BYTES = 3'd1;
  localparam logic [2:0] S_COMP = 3'd2;
  localparam logic [2:0] S_PAD = 3'd3;
  localparam logic [2:0] S_OUT = 3'd4;

  logic [2:0]   state;
  logic [2:0]   ret_state;
  word_t        cur_word;
  logic [2:0]   byte_cnt;
  logic [2:0]   byte_pos;
  logic         is_last;
  logic         pad_first;
  logic [63:0]  bits;
  logic [2:0]   len_idx;
  word_t [15:0] block_words;
  logic [5:0]   block_fill;
  logic [63:0]  byte_total;
  chain_t       chain;
  chain_t       chain_new;
  comp_ctl_t    ctl;
  logic         comp_start;
  logic         block_full;
  logic [7:0]   next_byte;
  logic         take_byte;
  logic         byte_done;

  sha_round u_round (
    .clk       (clk),
    .rst       (rst),
    .start     (comp_start),
    .block_in  (block_words),
    .chain_in  (chain),
    .ctl       (ctl),
    .chain_out (chain_new)
  );

  assign in_ready = (state == S_IDLE);
  assign out_valid = (state == S_OUT);
  assign digest_word = chain[word_index];
  assign digest_end = (word_index == 3'd7);

  // byte source for packer
  always_comb begin
    next_byte = 8'h00;
    take_byte = 1'b0;
    byte_done = 1'b0;
    unique case (state)
      S_BYTES: begin
        if (byte_pos < byte_cnt) begin
          next_byte = cur_word[31 - 8 * byte_pos -: 8];
          take_byte = 1'b1;
        end else begin
          byte_done = 1'b1;
        end
      end
      S_PAD: begin
        take_byte = 1'b1;
        if (pad_first) begin
          next_byte = PadByte;
        end else if (block_fill == LenPos || len_idx != 3'd0) begin
          next_byte = bits[63 - 8 * len_idx -: 8];
        end
      end
      default: begin
      end
    endcase
  end

  assign block_full = take_byte && (block_fill == 6'd63);
  // unit starts once the full block has settled
  assign comp_start = (state == S_COMP) && !ctl.busy && !ctl.done;

  always_ff @(posedge clk) begin
    if (take_byte) begin
      if (block_fill[1:0] == 2'd0) begin
        block_words[block_fill[5:2]] <= {next_byte, 24'h000000};
      end else begin
        block_words[block_fill[5:2]][31 - 8 * block_fill[1:0] -: 8] <= next_byte;
      end
    end
    if (state == S_IDLE && in_valid) begin
      cur_word <= data_word;
      byte_cnt <= (valid_bytes > 3'd4) ? 3'd4 : valid_bytes;
      is_last <= last_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ret_state <= S_IDLE;
      chain <= InitHash;
      block_fill <= '0;
      byte_total <= '0;
      byte_pos <= '0;
      pad_first <= 1'b0;
      len_idx <= '0;
      bits <= '0;
      word_index <= '0;
    end else begin
      if (take_byte) begin
        block_fill <= block_fill + 6'd1;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_BYTES;
            byte_pos <= '0;
          end
        end
        S_BYTES: begin
          if (take_byte) begin
            byte_pos <= byte_pos + 3'd1;
            byte_total <= byte_total + 64'd1;
            if (block_full) begin
              state <= S_COMP;
              ret_state <= S_BYTES;
            end
          end else if (byte_done) begin
            if (is_last) begin
              state <= S_PAD;
              pad_first <= 1'b1;
              len_idx <= '0;
              bits <= {byte_total[60:0], 3'b000};
            end else begin
              state <= S_IDLE;
            end
          end
        end
        S_PAD: begin
          pad_first <= 1'b0;
          if (!pad_first && (block_fill == LenPos || len_idx != 3'd0)) begin
            len_idx <= len_idx + 3'd1;
          end
          if (block_full) begin
            state <= S_COMP;
            ret_state <= (!pad_first && len_idx == 3'd7) ? S_OUT : S_PAD;
          end
        end
        S_COMP: begin
          if (ctl.done) begin
            chain <= chain_new;
            state <= ret_state;
            word_index <= '0;
          end
        end
        S_OUT: begin
          if (out_ready) begin
            word_index <= word_index + 3'd1;
            if (word_index == 3'd7) begin
              state <= S_IDLE;
              chain <= InitHash;
              block_fill <= '0;
              byte_total <= '0;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `include "sha256_message_hasher_macros.svh"

  `SHA_ASSERT_IMP(a_comp_only_in_comp, ctl.busy, state == S_COMP)
  `SHA_ASSERT_IMP(a_out_needs_idle_unit, out_valid, !ctl.busy)
  `SHA_ASSERT_NEXT(a_last_digest_ends, out_valid && out_ready && digest_end,
                   state == S_IDLE && block_fill == '0)

endmodule
